// ===== hw/rtl/csc_pkg.sv =====
// Shared types and constants for the color sensor classifier.
package csc_pkg;

   localparam int CNT_W     = 16;
   localparam int REF_W     = 42;
   localparam int FIELD_W   = 14;
   localparam int QBITS     = 14;
   localparam int REM_BITS  = 30;
   localparam int NUM_REFS  = 6;
   localparam int NUM_CH    = 3;
   localparam int NUM_LANES = 6;
   localparam int NORM_W    = 8;
   localparam int SQ_W      = 28;
   localparam int DIST_W    = 30;
   localparam int EN_W      = 7;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;

   localparam logic [FIELD_W-1:0] RATIO_MAX   = 14'h3FFF;
   localparam logic [FIELD_W-1:0] RATIO_SCALE = 14'd10000;
   localparam logic [NORM_W-1:0]  NORM_MAX    = 8'd255;
   localparam logic [NORM_W-1:0]  NORM_SCALE  = 8'd255;
   localparam logic [DIST_W-1:0]  DIST_LIMIT  = 30'd600000;
   localparam logic [CNT_W-1:0]   MIN_CLEAR   = 16'd20;
   localparam logic [CNT_W-1:0]   BLACK_CLEAR = 16'd120;
   localparam logic [CNT_W-1:0]   WHITE_CLEAR = 16'd200;

   localparam logic [FIELD_W-1:0] WHITE_TOL    = 14'd700;
   localparam logic [FIELD_W-1:0] YELLOW_TOL   = 14'd1200;
   localparam logic [FIELD_W-1:0] YELLOW_B_TOL = 14'd800;
   localparam logic [FIELD_W:0]   YELLOW_RG    = 15'd600;
   localparam logic [FIELD_W:0]   RED_REF_TOL  = 15'd800;
   localparam logic [FIELD_W:0]   RED_MARGIN   = 15'd1500;
   localparam logic [FIELD_W:0]   BLUE_REF_TOL = 15'd800;
   localparam logic [FIELD_W:0]   BLUE_R_MARGIN = 15'd1200;
   localparam logic [FIELD_W:0]   BLUE_G_MARGIN = 15'd1000;
   localparam logic [FIELD_W:0]   GREEN_REF_TOL = 15'd1000;
   localparam logic [FIELD_W:0]   GREEN_R_MARGIN = 15'd1000;
   localparam logic [FIELD_W:0]   GREEN_B_MARGIN = 15'd800;

   // reference / enable bit indexes
   localparam int REF_RED    = 0;
   localparam int REF_GREEN  = 1;
   localparam int REF_BLUE   = 2;
   localparam int REF_YELLOW = 3;
   localparam int REF_WHITE  = 4;
   localparam int REF_BLACK  = 5;
   localparam int EN_CLASSIFY = 6;

   localparam int CH_R = 0;
   localparam int CH_G = 1;
   localparam int CH_B = 2;

   localparam logic [2:0] REG_CLASS_ENABLE = 3'd6;

   typedef enum logic [2:0] {
      CLS_UNKNOWN = 3'd0,
      CLS_RED     = 3'd1,
      CLS_GREEN   = 3'd2,
      CLS_BLUE    = 3'd3,
      CLS_YELLOW  = 3'd4,
      CLS_WHITE   = 3'd5,
      CLS_BLACK   = 3'd6
   } csc_class_type;

   // lanes 0-2: ratios r, g, b; lanes 3-5: normalized r, g, b
   typedef struct packed {
      logic [CNT_W-1:0]                   clear;
      logic [NUM_LANES-1:0][REM_BITS-1:0] rem;
      logic [NUM_LANES-1:0][QBITS-1:0]    quo;
      logic [NUM_LANES-1:0]               sat;
   } csc_div_type;

   typedef struct packed {
      logic [NUM_REFS-1:0][REF_W-1:0] refs;
      logic [EN_W-1:0]                enable;
   } csc_cfg_type;

endpackage

// ===== hw/rtl/csc_req_if.sv =====
// Reading channel: one sensor sample per beat.
interface csc_req_if import csc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CNT_W-1:0] clear_count;
   logic [CNT_W-1:0] red_count;
   logic [CNT_W-1:0] green_count;
   logic [CNT_W-1:0] blue_count;

   modport source(output valid, clear_count, red_count, green_count, blue_count,
                  input ready);
   modport sink(input valid, clear_count, red_count, green_count, blue_count,
                output ready);
endinterface

// ===== hw/rtl/csc_rsp_if.sv =====
// Result channel: class and normalized channels per beat.
interface csc_rsp_if import csc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [2:0]        color_class;
   logic [NORM_W-1:0] norm_red;
   logic [NORM_W-1:0] norm_green;
   logic [NORM_W-1:0] norm_blue;

   modport source(output valid, color_class, norm_red, norm_green, norm_blue,
                  input ready);
   modport sink(input valid, color_class, norm_red, norm_green, norm_blue,
                output ready);
endinterface

// ===== hw/rtl/csc_div_cell.sv =====
// One restoring-division cell: resolves one quotient bit in all six lanes.
module csc_div_cell import csc_pkg::*; #(
   parameter int BIT = 0
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  csc_div_type in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output csc_div_type out_data
);

   logic        valid_ff;
   csc_div_type data_ff;
   csc_div_type data_in;
   logic [REM_BITS-1:0] dsh;

   assign dsh = REM_BITS'(in_data.clear) << BIT;

   always_comb begin
      data_in = in_data;
      for (int l = 0; l < NUM_LANES; l++) begin
         if (in_data.rem[l] >= dsh) begin
            data_in.rem[l]      = in_data.rem[l] - dsh;
            data_in.quo[l][BIT] = 1'b1;
         end
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== hw/rtl/csc_class.sv =====
// Classifier: channel distances, override rules and nearest reference, two stages.
module csc_class import csc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  csc_cfg_type       cfg,
   input  logic              in_valid,
   output logic              in_ready,
   input  csc_div_type       in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [2:0]        color_class,
   output logic [NORM_W-1:0] norm_red,
   output logic [NORM_W-1:0] norm_green,
   output logic [NORM_W-1:0] norm_blue
);

   // stage 1 registers
   logic                                       v1_ff;
   logic [CNT_W-1:0]                           clear_ff;
   logic [NUM_CH-1:0][FIELD_W-1:0]             q_ff;
   logic [NUM_CH-1:0][NORM_W-1:0]              nrm_ff;
   logic [NUM_REFS-1:0][NUM_CH-1:0][FIELD_W-1:0] ad_ff;
   logic [NUM_REFS-1:0][NUM_CH-1:0][SQ_W-1:0]  sq_ff;

   logic [NUM_CH-1:0][FIELD_W-1:0]             q_in;
   logic [NUM_CH-1:0][NORM_W-1:0]              nrm_in;
   logic [NUM_REFS-1:0][NUM_CH-1:0][FIELD_W-1:0] ad_in;
   logic [NUM_REFS-1:0][NUM_CH-1:0][SQ_W-1:0]  sq_in;

   // stage 2 (output) registers
   logic                          v2_ff;
   csc_class_type                 cls_ff;
   logic [NUM_CH-1:0][NORM_W-1:0] out_nrm_ff;
   csc_class_type                 cls_in;

   logic ready1;
   logic ready2;

   assign ready2   = !v2_ff || out_ready;
   assign ready1   = !v1_ff || ready2;
   assign in_ready = ready1;

   always_comb begin
      logic [FIELD_W-1:0] rf;
      rf = '0;
      for (int c = 0; c < NUM_CH; c++) begin
         q_in[c] = in_data.sat[c] ? RATIO_MAX : in_data.quo[c];
         if (in_data.clear == '0) begin
            nrm_in[c] = '0;
         end else if (in_data.sat[NUM_CH+c] || (|in_data.quo[NUM_CH+c][QBITS-1:NORM_W])) begin
            nrm_in[c] = NORM_MAX;
         end else begin
            nrm_in[c] = in_data.quo[NUM_CH+c][NORM_W-1:0];
         end
      end
      for (int i = 0; i < NUM_REFS; i++) begin
         for (int c = 0; c < NUM_CH; c++) begin
            rf = cfg.refs[i][FIELD_W*c +: FIELD_W];
            ad_in[i][c] = (rf > q_in[c]) ? rf - q_in[c] : q_in[c] - rf;
            sq_in[i][c] = SQ_W'(ad_in[i][c]) * SQ_W'(ad_in[i][c]);
         end
      end
   end

   always_comb begin
      logic [NUM_REFS-1:0][DIST_W-1:0] ref_dist;
      logic [DIST_W-1:0]  best_dist;
      logic [2:0]         best_idx;
      logic               found;
      logic [FIELD_W:0]   qr, qg, qb;
      logic               en_black, en_white, en_yellow, en_red, en_blue, en_green;
      found     = 1'b0;
      best_dist = '0;
      best_idx  = '0;
      qr = {1'b0, q_ff[CH_R]};
      qg = {1'b0, q_ff[CH_G]};
      qb = {1'b0, q_ff[CH_B]};
      // scan references in order; strict less keeps the lower index on a tie
      for (int i = 0; i < NUM_REFS; i++) begin
         ref_dist[i] = DIST_W'(sq_ff[i][CH_R]) + DIST_W'(sq_ff[i][CH_G]) +
                       DIST_W'(sq_ff[i][CH_B]);
         if (cfg.enable[i] && (!found || ref_dist[i] < best_dist)) begin
            found     = 1'b1;
            best_dist = ref_dist[i];
            best_idx  = 3'(i);
         end
      end
      en_black  = cfg.enable[REF_BLACK] && clear_ff < BLACK_CLEAR;
      en_white  = cfg.enable[REF_WHITE] && clear_ff > WHITE_CLEAR &&
                  ad_ff[REF_WHITE][CH_R] < WHITE_TOL &&
                  ad_ff[REF_WHITE][CH_G] < WHITE_TOL &&
                  ad_ff[REF_WHITE][CH_B] < WHITE_TOL;
      en_yellow = cfg.enable[REF_YELLOW] &&
                  ad_ff[REF_YELLOW][CH_R] < YELLOW_TOL &&
                  ad_ff[REF_YELLOW][CH_G] < YELLOW_TOL &&
                  ad_ff[REF_YELLOW][CH_B] < YELLOW_B_TOL &&
                  (qr + YELLOW_RG >= qg);
      en_red    = cfg.enable[REF_RED] &&
                  (qr + RED_REF_TOL > {1'b0, cfg.refs[REF_RED][FIELD_W*CH_R +: FIELD_W]}) &&
                  (qr > qg + RED_MARGIN) && (qr > qb + RED_MARGIN);
      en_blue   = cfg.enable[REF_BLUE] &&
                  (qb + BLUE_REF_TOL > {1'b0, cfg.refs[REF_BLUE][FIELD_W*CH_B +: FIELD_W]}) &&
                  (qb > qr + BLUE_R_MARGIN) && (qb > qg + BLUE_G_MARGIN);
      en_green  = cfg.enable[REF_GREEN] &&
                  (qg + GREEN_REF_TOL > {1'b0, cfg.refs[REF_GREEN][FIELD_W*CH_G +: FIELD_W]}) &&
                  (qg > qr + GREEN_R_MARGIN) && (qg > qb + GREEN_B_MARGIN);
      if (!cfg.enable[EN_CLASSIFY] || clear_ff < MIN_CLEAR) begin
         cls_in = CLS_UNKNOWN;
      end else if (en_black) begin
         cls_in = CLS_BLACK;
      end else if (en_white) begin
         cls_in = CLS_WHITE;
      end else if (en_yellow) begin
         cls_in = CLS_YELLOW;
      end else if (en_red) begin
         cls_in = CLS_RED;
      end else if (en_blue) begin
         cls_in = CLS_BLUE;
      end else if (en_green) begin
         cls_in = CLS_GREEN;
      end else if (!found || best_dist > DIST_LIMIT) begin
         cls_in = CLS_UNKNOWN;
      end else begin
         cls_in = csc_class_type'(best_idx + 3'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (ready1) v1_ff <= in_valid;
         if (ready2) v2_ff <= v1_ff;
      end
      if (ready1 && in_valid) begin
         clear_ff <= in_data.clear;
         q_ff     <= q_in;
         nrm_ff   <= nrm_in;
         ad_ff    <= ad_in;
         sq_ff    <= sq_in;
      end
      if (ready2 && v1_ff) begin
         cls_ff     <= cls_in;
         out_nrm_ff <= nrm_ff;
      end
   end

   assign out_valid   = v2_ff;
   assign color_class = cls_ff;
   assign norm_red    = out_nrm_ff[CH_R];
   assign norm_green  = out_nrm_ff[CH_G];
   assign norm_blue   = out_nrm_ff[CH_B];

endmodule

// ===== hw/rtl/color_sensor_classifier_core.sv =====
// Top level of the color sensor classifier: register file, divider chain, classifier.
// Takes one clear/red/green/blue reading per clock while the result side keeps up
// and returns one class plus normalized channels per reading. The path is one
// entry register that scales the counts, a chain of 14 division cells
// (one quotient bit each, six quotients in parallel) and two classifier stages
// (squared distances, then rules and nearest reference), the last one being the
// output register. Every stage holds its beat under backpressure and takes a new
// one as soon as its successor moves. Reference and enable registers are written
// over the APB port, 64-bit data at byte address 8 * index.
module color_sensor_classifier_core import csc_pkg::*; #(
   parameter int COUNT_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   csc_req_if.sink               req,
   csc_rsp_if.source             rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam logic [CNT_W-1:0] CountMask = CNT_W'((17'd1 << COUNT_BITS) - 17'd1);

   // configuration registers
   logic [NUM_REFS-1:0][REF_W-1:0] ref_ff;
   logic [EN_W-1:0]                enable_ff;
   logic [2:0]                     csr_index;
   logic                           csr_write;
   csc_cfg_type                    cfg;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[5:3];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff    <= '0;
         enable_ff <= '0;
      end else if (csr_write) begin
         if (csr_index == REG_CLASS_ENABLE) begin
            enable_ff <= csr_pwdata[EN_W-1:0];
         end else if (32'(csr_index) < NUM_REFS) begin
            ref_ff[csr_index] <= csr_pwdata[REF_W-1:0];
         end
      end
   end

   always_comb begin
      if (csr_index == REG_CLASS_ENABLE) begin
         csr_prdata = CSR_DATA_W'(enable_ff);
      end else if (32'(csr_index) < NUM_REFS) begin
         csr_prdata = CSR_DATA_W'(ref_ff[csr_index]);
      end else begin
         csr_prdata = '0;
      end
   end

   assign cfg.refs   = ref_ff;
   assign cfg.enable = enable_ff;

   // entry stage: scale counts into six numerators and flag saturation
   logic [QBITS:0]  valid_w;
   logic [QBITS:0]  ready_w;
   csc_div_type     data_w [QBITS+1];
   logic            entry_valid_ff;
   csc_div_type     entry_ff;
   csc_div_type     entry_in;
   logic [NUM_CH-1:0][CNT_W-1:0] cnt;
   logic [CNT_W-1:0] clr;

   assign clr    = req.clear_count & CountMask;
   assign cnt[CH_R] = req.red_count & CountMask;
   assign cnt[CH_G] = req.green_count & CountMask;
   assign cnt[CH_B] = req.blue_count & CountMask;

   always_comb begin
      logic [REM_BITS:0] lim;
      lim = {1'b0, REM_BITS'(clr)} << QBITS;
      entry_in.clear = clr;
      entry_in.quo   = '0;
      for (int c = 0; c < NUM_CH; c++) begin
         entry_in.rem[c]        = REM_BITS'(cnt[c]) * REM_BITS'(RATIO_SCALE);
         entry_in.rem[NUM_CH+c] = REM_BITS'(cnt[c]) * REM_BITS'(NORM_SCALE);
      end
      for (int l = 0; l < NUM_LANES; l++) begin
         entry_in.sat[l] = {1'b0, entry_in.rem[l]} >= lim;
      end
   end

   assign req.ready = !entry_valid_ff || ready_w[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else if (req.ready) begin
         entry_valid_ff <= req.valid;
      end
      if (req.ready && req.valid) begin
         entry_ff <= entry_in;
      end
   end

   assign valid_w[0] = entry_valid_ff;
   assign data_w[0]  = entry_ff;

   // division chain, most significant quotient bit first
   for (genvar j = 0; j < QBITS; j++) begin : g_cell
      csc_div_cell #(.BIT(QBITS-1-j)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_w[j]),
         .in_ready  (ready_w[j]),
         .in_data   (data_w[j]),
         .out_valid (valid_w[j+1]),
         .out_ready (ready_w[j+1]),
         .out_data  (data_w[j+1])
      );
   end

   csc_class u_class (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .in_valid    (valid_w[QBITS]),
      .in_ready    (ready_w[QBITS]),
      .in_data     (data_w[QBITS]),
      .out_valid   (rsp.valid),
      .out_ready   (rsp.ready),
      .color_class (rsp.color_class),
      .norm_red    (rsp.norm_red),
      .norm_green  (rsp.norm_green),
      .norm_blue   (rsp.norm_blue)
   );

`ifndef NO_ASSERTIONS
   // an accepted beat lands in the entry register
   a_entry_load: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> entry_valid_ff)
      else $error("accepted beat not held in entry stage");

   // enable write takes effect on the next cycle
   a_enable_write: assert property (@(posedge clock) disable iff (reset)
      csr_write && csr_index == REG_CLASS_ENABLE |=> enable_ff == $past(csr_pwdata[EN_W-1:0]))
      else $error("class enable write lost");

   // a zero clear count saturates the red ratio lane (such a beat never classifies)
   a_zero_clear: assert property (@(posedge clock) disable iff (reset)
      valid_w[QBITS] && data_w[QBITS].clear == '0 |-> data_w[QBITS].sat[CH_R])
      else $error("zero clear count not saturated");

   // the class code never exceeds the last defined class
   a_class_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.color_class <= CLS_BLACK)
      else $error("class code out of range");
`endif

endmodule
